// ===== rtl/bla_pkg.sv =====
`timescale 1ns / 1ps

package bla_pkg;

   // ring and field widths
   localparam int RING_DEPTH = 16;
   localparam int SAMPLE_W   = 12;
   localparam int GAIN_W     = 5;
   localparam int CELLS_W    = 4;
   localparam int MV_W       = 16;
   localparam int LEVEL_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // running sum holds RING_DEPTH full-scale samples
   localparam int SUM_W = $clog2(RING_DEPTH * ((1 << SAMPLE_W) - 1) + 1);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   // shared divider: quotient register and remainder widths
   localparam int PROD_W = SAMPLE_W + GAIN_W;
   localparam int DIV_W  = PROD_W;
   localparam int REM_W  = MV_W;
   localparam int STEP_W = $clog2(DIV_W + 1);
   localparam int NUM_W  = MV_W + LEVEL_W;

   localparam logic [LEVEL_W-1:0] PCT_FULL = LEVEL_W'(100);
   localparam logic [LEVEL_W-1:0] PCT_NONE = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIVIDER_GAIN    = 2'd0,
      CSR_CELLS_IN_SERIES = 2'd1,
      CSR_EMPTY_MV        = 2'd2,
      CSR_FULL_MV         = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_CELL_GO,
      ST_CELL_WAIT,
      ST_LVL_GO,
      ST_LVL_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [REM_W-1:0]  rem_init;
      logic [DIV_W-1:0]  low;
      logic [REM_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;

endpackage

// ===== rtl/bla_cell.sv =====
`timescale 1ns / 1ps

// one sample slot of the history chain
module bla_cell import bla_pkg::*; (
   input  logic                clock,
   input  logic                shift_en,
   input  logic [SAMPLE_W-1:0] d_in,
   output logic [SAMPLE_W-1:0] q_out
);

   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] sample_in;

   assign sample_in = shift_en ? d_in : sample_ff;

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign q_out = sample_ff;

endmodule

// ===== rtl/bla_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module bla_div import bla_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0]  divisor_ff, divisor_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W:0] trial;
   logic [REM_W:0] trial_sub;
   logic           fits;

   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign fits      = trial >= {1'b0, divisor_ff};
   assign trial_sub = trial - {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         rem_in     = div_req.rem_init;
         quo_in     = div_req.low;
         divisor_in = div_req.divisor;
         cnt_in     = div_req.steps;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

// ===== rtl/battery_level_averager.sv =====
`timescale 1ns / 1ps
// Levels that clamp to 0 or 100 skip the level division; all three divisions run on the
//   shared one-bit-per-cycle divider (12 + 17 + 7 steps).
// Flow: one sample at a time, held up while an older result still holds the
//   output register; the next sample is taken once the result sits there, even while it waits.
// Reset: synchronous, active high; clears the history count, running sum, handshakes and
//   loads the config defaults (gain 2, 1 cell, 3300 mV empty, 4200 mV full).

module battery_level_averager import bla_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_sample_mv,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LEVEL_W-1:0]    rsp_level_percent,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // Config registers
   // ------------------------------------------------------------------
   logic [GAIN_W-1:0]  gain_ff;
   logic [CELLS_W-1:0] cells_ff;
   logic [MV_W-1:0]    empty_mv_ff;
   logic [MV_W-1:0]    full_mv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= GAIN_W'(2);
         cells_ff    <= CELLS_W'(1);
         empty_mv_ff <= MV_W'(3300);
         full_mv_ff  <= MV_W'(4200);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIVIDER_GAIN:    gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_CELLS_IN_SERIES: cells_ff    <= csr_wdata[CELLS_W-1:0];
            CSR_EMPTY_MV:        empty_mv_ff <= csr_wdata[MV_W-1:0];
            CSR_FULL_MV:         full_mv_ff  <= csr_wdata[MV_W-1:0];
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sample history: a chain of cells that shifts once per req transfer.
   // The last cell holds the sample that leaves the window.
   // ------------------------------------------------------------------
   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   logic [SAMPLE_W-1:0] tap [RING_DEPTH+1];
   assign tap[0] = req_sample_mv;

   for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
      bla_cell u_cell (
         .clock    (clock),
         .shift_en (req_xfer),
         .d_in     (tap[i]),
         .q_out    (tap[i+1])
      );
   end

   // count of samples in the window, saturates at the depth
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             window_full;

   assign window_full = count_ff == CNT_W'(RING_DEPTH);

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (req_xfer) begin
         if (!window_full) begin
            count_in = count_ff + CNT_W'(1);
         end
         // wraps cleanly: the true sum always fits SUM_W
         sum_in = sum_ff + SUM_W'(req_sample_mv)
                  - (window_full ? SUM_W'(tap[RING_DEPTH]) : SUM_W'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // ------------------------------------------------------------------
   // Shared divider
   // ------------------------------------------------------------------
   div_req_type div_req;
   div_rsp_type div_rsp;

   bla_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ------------------------------------------------------------------
   // Datapath operands
   // ------------------------------------------------------------------
   logic [SAMPLE_W-1:0] avg_ff;
   logic [DIV_W-1:0]    cell_mv_ff;
   logic [LEVEL_W-1:0]  level_ff;

   logic [PROD_W-1:0]  pack_prod;   // average times divider gain
   logic [CELLS_W-1:0] cells_eff;   // zero cells counts as one
   logic [MV_W-1:0]    span_mv;
   logic [MV_W-1:0]    above_empty;
   logic [NUM_W-1:0]   level_num;
   logic               at_empty;
   logic               at_full;

   assign pack_prod   = PROD_W'(avg_ff) * PROD_W'(gain_ff);
   assign cells_eff   = (cells_ff == '0) ? CELLS_W'(1) : cells_ff;
   assign span_mv     = full_mv_ff - empty_mv_ff;
   assign above_empty = cell_mv_ff[MV_W-1:0] - empty_mv_ff;
   assign level_num   = NUM_W'(above_empty) * NUM_W'(PCT_FULL);
   // empty test wins over full test when full is not above empty
   assign at_empty    = cell_mv_ff <= DIV_W'(empty_mv_ff);
   assign at_full     = cell_mv_ff >= DIV_W'(full_mv_ff);

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   state_type state_ff, state_in;

   logic               avg_ld;
   logic               cell_ld;
   logic               lvl_ld;
   logic [LEVEL_W-1:0] lvl_val;
   logic               rsp_ld;
   logic               out_free;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_AVG_GO;
         ST_AVG_GO:    state_in = ST_AVG_WAIT;
         ST_AVG_WAIT:  if (div_rsp.done) state_in = ST_CELL_GO;
         ST_CELL_GO:   state_in = ST_CELL_WAIT;
         ST_CELL_WAIT: if (div_rsp.done) state_in = ST_LVL_GO;
         ST_LVL_GO:    state_in = (at_empty || at_full) ? ST_OUT : ST_LVL_WAIT;
         ST_LVL_WAIT:  if (div_rsp.done) state_in = ST_OUT;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      div_req   = '0;
      avg_ld    = 1'b0;
      cell_ld   = 1'b0;
      lvl_ld    = 1'b0;
      lvl_val   = PCT_NONE;
      rsp_ld    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_AVG_GO: begin
            // average < 2^SAMPLE_W, so only the low SAMPLE_W quotient bits are worked out
            div_req.start    = 1'b1;
            div_req.steps    = STEP_W'(SAMPLE_W);
            div_req.rem_init = REM_W'(sum_ff >> SAMPLE_W);
            div_req.low      = {sum_ff[SAMPLE_W-1:0], {(DIV_W-SAMPLE_W){1'b0}}};
            div_req.divisor  = REM_W'(count_ff);
         end
         ST_AVG_WAIT: begin
            avg_ld = div_rsp.done;
         end
         ST_CELL_GO: begin
            div_req.start    = 1'b1;
            div_req.steps    = STEP_W'(PROD_W);
            div_req.rem_init = '0;
            div_req.low      = DIV_W'(pack_prod);
            div_req.divisor  = REM_W'(cells_eff);
         end
         ST_CELL_WAIT: begin
            cell_ld = div_rsp.done;
         end
         ST_LVL_GO: begin
            if (at_empty) begin
               lvl_ld  = 1'b1;
               lvl_val = PCT_NONE;
            end else if (at_full) begin
               lvl_ld  = 1'b1;
               lvl_val = PCT_FULL;
            end else begin
               // level < 128, so the upper numerator bits already sit below the span
               div_req.start    = 1'b1;
               div_req.steps    = STEP_W'(LEVEL_W);
               div_req.rem_init = REM_W'(level_num[NUM_W-1:LEVEL_W]);
               div_req.low      = {level_num[LEVEL_W-1:0], {(DIV_W-LEVEL_W){1'b0}}};
               div_req.divisor  = span_mv;
            end
         end
         ST_LVL_WAIT: begin
            lvl_ld  = div_rsp.done;
            lvl_val = div_rsp.quo[LEVEL_W-1:0];
         end
         ST_OUT: begin
            rsp_ld = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (avg_ld) begin
         avg_ff <= div_rsp.quo[SAMPLE_W-1:0];
      end
      if (cell_ld) begin
         cell_mv_ff <= div_rsp.quo;
      end
      if (lvl_ld) begin
         level_ff <= lvl_val;
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ld) begin
         rsp_level_ff <= level_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level_percent = rsp_level_ff;

endmodule

// ===== rtl/bla_checker.sv =====
`timescale 1ns / 1ps

module bla_checker import bla_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [LEVEL_W-1:0]    rsp_level_percent
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level_percent))
      else $error("result changed while stalled");

   // level stays in percent range
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level_percent <= PCT_FULL)
      else $error("level above 100 percent");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one sample at a time: busy right after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample taken while busy");

endmodule

bind battery_level_averager bla_checker u_bla_checker (.*);

// ===== sim/battery_level_averager_checker.sv =====
`timescale 1ns / 1ps

module battery_level_averager_checker import bla_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_sample_mv,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [LEVEL_W-1:0]    rsp_level_percent,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           fail_count,
   output int unsigned           pending_count,
   output int unsigned           levels_checked,
   output int unsigned           empty_levels,
   output int unsigned           full_levels
);

   localparam logic [GAIN_W-1:0]  GAIN_AT_RESET  = GAIN_W'(2);
   localparam logic [CELLS_W-1:0] CELLS_AT_RESET = CELLS_W'(1);
   localparam logic [MV_W-1:0]    EMPTY_AT_RESET = MV_W'(3300);
   localparam logic [MV_W-1:0]    FULL_AT_RESET  = MV_W'(4200);

   typedef struct {
      logic [SAMPLE_W-1:0] sample_mv;
      logic [LEVEL_W-1:0]  level;
   } level_expect_type;

   level_expect_type expected_levels[$];

   // sample history, mirrors the block's ring
   logic [SAMPLE_W-1:0] history [RING_DEPTH];
   int unsigned         history_pos;
   logic                history_wrapped;
   int unsigned         history_sum;

   logic [GAIN_W-1:0]   gain;
   logic [CELLS_W-1:0]  cells;
   logic [MV_W-1:0]     empty_mv;
   logic [MV_W-1:0]     full_mv;

   function automatic logic [LEVEL_W-1:0] next_level_percent(
      input logic [SAMPLE_W-1:0] sample_mv
   );
      int unsigned count;
      int unsigned avg_mv;
      int unsigned cell_mv;
      int unsigned cell_count;
      if (history_wrapped) begin
         history_sum -= history[history_pos];
      end
      history[history_pos] = sample_mv;
      history_sum += sample_mv;
      history_pos++;
      if (history_pos >= RING_DEPTH) begin
         history_pos     = 0;
         history_wrapped = 1'b1;
      end
      count = history_wrapped ? RING_DEPTH : history_pos;
      if (count == 0) begin
         count = 1;
      end
      avg_mv = history_sum / count;
      // a cell count of zero divides by one
      cell_count = (cells == '0) ? 1 : cells;
      cell_mv    = (avg_mv * gain) / cell_count;
      // empty test wins, so full <= empty never reaches the linear part
      if (cell_mv <= empty_mv) begin
         return PCT_NONE;
      end
      if (cell_mv >= full_mv) begin
         return PCT_FULL;
      end
      return LEVEL_W'(((cell_mv - empty_mv) * 100) / (full_mv - empty_mv));
   endfunction

   always @(posedge clock) begin
      level_expect_type head;
      level_expect_type item;
      if (reset) begin
         expected_levels.delete();
         history_pos     = 0;
         history_wrapped = 1'b0;
         history_sum     = 0;
         gain            = GAIN_AT_RESET;
         cells           = CELLS_AT_RESET;
         empty_mv        = EMPTY_AT_RESET;
         full_mv         = FULL_AT_RESET;
         fail_count      = 0;
         levels_checked  = 0;
         empty_levels    = 0;
         full_levels     = 0;
      end else begin
         // result side first: a result here belongs to an older sample
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: level %0d transferred with no sample outstanding",
                        $time, rsp_level_percent);
               fail_count++;
            end else begin
               head = expected_levels.pop_front();
               levels_checked++;
               if (head.level == PCT_NONE) empty_levels++;
               if (head.level == PCT_FULL) full_levels++;
               if (rsp_level_percent !== head.level) begin
                  $display("%0t: level mismatch for sample %0d mV: expected %0d, actual %0d",
                           $time, head.sample_mv, head.level, rsp_level_percent);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            item.sample_mv = req_sample_mv;
            item.level     = next_level_percent(req_sample_mv);
            expected_levels.push_back(item);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DIVIDER_GAIN:    gain     = csr_wdata[GAIN_W-1:0];
               CSR_CELLS_IN_SERIES: cells    = csr_wdata[CELLS_W-1:0];
               CSR_EMPTY_MV:        empty_mv = csr_wdata[MV_W-1:0];
               CSR_FULL_MV:         full_mv  = csr_wdata[MV_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= expected_levels.size();
   end

endmodule

// ===== sim/battery_level_averager_tb.sv =====
`timescale 1ns / 1ps

module battery_level_averager_tb;
   import bla_pkg::*;

   localparam int unsigned SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
   localparam int unsigned MV_MAX         = (1 << MV_W) - 1;
   localparam int unsigned RESET_CYCLES   = 11;
   // idle time after the last level comes back, before registers may change
   localparam int unsigned SETTLE_CYCLES  = 60;
   localparam int unsigned RAND_PHASES    = 10;
   localparam int unsigned PHASE_SAMPLES  = 100;
   localparam int unsigned CYCLE_LIMIT    = 2000000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_sample_mv;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [LEVEL_W-1:0]    rsp_level_percent;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned levels_checked;
   int unsigned empty_levels;
   int unsigned full_levels;

   int unsigned samples_sent;
   int unsigned csr_writes;
   int unsigned settings_run;
   int unsigned cycle_count;

   battery_level_averager i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_mv     (req_sample_mv),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level_percent (rsp_level_percent),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // watches all three ports, predicts every level and counts failures
   battery_level_averager_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_mv     (req_sample_mv),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level_percent (rsp_level_percent),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .levels_checked    (levels_checked),
      .empty_levels      (empty_levels),
      .full_levels       (full_levels)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // hard stop in case a transfer never completes
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d levels still outstanding",
                  cycle_count, pending_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side back-pressure. Mostly short ready/stall runs, now and then a
   // long stall that holds a finished level in the output register, and now
   // and then a long always-ready stretch.
   initial begin
      int unsigned hold;
      int unsigned pick;
      logic        level;
      rsp_ready = 1'b0;
      forever begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            level = 1'b1;
            hold  = $urandom_range(100, 400);
         end else if (pick < 55) begin
            level = 1'b1;
            hold  = $urandom_range(1, 12);
         end else if (pick < 92) begin
            level = 1'b0;
            hold  = $urandom_range(1, 5);
         end else begin
            level = 1'b0;
            hold  = $urandom_range(30, 150);
         end
         @(negedge clock);
         rsp_ready <= level;
         repeat (hold - 1) @(negedge clock);
      end
   end

   // idle cycles ahead of a sample: mostly none or a few, sometimes long
   function automatic int unsigned pick_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   // samples cluster around a center so the average settles in the linear span
   function automatic int unsigned pick_sample(input int unsigned center_mv);
      int unsigned pick;
      int          value;
      pick = $urandom_range(0, 99);
      if (pick < 8) return (pick % 2) ? SAMPLE_MAX : 0;
      if (pick < 55) begin
         value = int'(center_mv) + int'($urandom_range(0, 300)) - 150;
         if (value < 0) value = 0;
         if (value > int'(SAMPLE_MAX)) value = SAMPLE_MAX;
         return value;
      end
      return $urandom_range(0, SAMPLE_MAX);
   endfunction

   // drive one sample after gap idle cycles, return once it transfers
   task automatic send_sample(input int unsigned sample_mv, input int unsigned gap);
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_sample_mv <= SAMPLE_W'(sample_mv);
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(negedge clock);
      csr_we    <= 1'b0;
      csr_writes++;
   endtask

   task automatic write_all_csrs(input int unsigned gain, input int unsigned cells,
                                 input int unsigned empty_mv, input int unsigned full_mv);
      write_csr(CSR_DIVIDER_GAIN, gain);
      write_csr(CSR_CELLS_IN_SERIES, cells);
      write_csr(CSR_EMPTY_MV, empty_mv);
      write_csr(CSR_FULL_MV, full_mv);
   endtask

   // stop driving, let every level come back, then let the block go idle
   // before registers may change
   task automatic finish_phase();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      settings_run++;
   endtask

   initial begin
      int unsigned phase;
      int unsigned n;
      int unsigned center_mv;
      int unsigned gain;
      int unsigned cells;
      int unsigned cell_mv;
      int unsigned span_mv;
      int unsigned empty_mv;
      int unsigned full_mv;
      bit          steady;

      samples_sent  = 0;
      csr_writes    = 0;
      settings_run  = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_sample_mv = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_DIVIDER_GAIN;
      csr_wdata     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // reset settings: gain 2, one cell, 3300..4200 mV; first samples average
      // over a partly filled history, so 1650/2100 do not land on the empty/full edges
      send_sample(0, 0);
      send_sample(SAMPLE_MAX, 0);
      send_sample(SAMPLE_MAX, 0);
      send_sample(1650, 0);
      send_sample(2100, 0);
      send_sample('hAAA, 0);
      send_sample('h555, 0);
      finish_phase();

      // gain 16 and 8 cells over the full per-cell range
      write_all_csrs(16, 8, 0, MV_MAX);
      send_sample(SAMPLE_MAX, 0);
      send_sample(0, 0);
      finish_phase();

      // gain write with bits above its width: masks to zero gain
      write_csr(CSR_DIVIDER_GAIN, 'hFFE0);
      send_sample(2000, 0);
      send_sample(SAMPLE_MAX, 0);
      finish_phase();
      // zero gain with full at zero as well
      write_csr(CSR_FULL_MV, 0);
      send_sample(SAMPLE_MAX, 0);
      send_sample(1000, 0);
      finish_phase();

      // cell count masks to zero and counts as one; the largest gain drives the
      // voltage past the top of the range
      write_all_csrs('h001F, 'hFFF0, MV_MAX, MV_MAX);
      send_sample(SAMPLE_MAX, 0);
      send_sample(3000, 0);
      finish_phase();

      // full below empty: only the clamps can apply
      write_all_csrs(1, 1, 3000, 1000);
      send_sample(500, 0);
      send_sample(2000, 0);
      send_sample(SAMPLE_MAX, 0);
      finish_phase();

      // full equal to empty
      write_all_csrs(1, 1, 2000, 2000);
      send_sample(1999, 0);
      send_sample(2000, 0);
      send_sample(2500, 0);
      finish_phase();

      // --- random ---
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         center_mv = $urandom_range(0, SAMPLE_MAX);
         case ($urandom_range(0, 9))
            6, 7: begin
               // corner settings
               case ($urandom_range(0, 3))
                  0: gain = 0;
                  1: gain = 1;
                  2: gain = 16;
                  default: gain = 31;
               endcase
               case ($urandom_range(0, 3))
                  0: cells = 0;
                  1: cells = 1;
                  2: cells = 8;
                  default: cells = 15;
               endcase
               case ($urandom_range(0, 2))
                  0: empty_mv = 0;
                  1: empty_mv = MV_MAX;
                  default: empty_mv = $urandom_range(0, MV_MAX);
               endcase
               case ($urandom_range(0, 2))
                  0: full_mv = 0;
                  1: full_mv = MV_MAX;
                  default: full_mv = $urandom_range(0, MV_MAX);
               endcase
            end
            8, 9: begin
               // raw words, upper bits included
               gain     = $urandom_range(0, MV_MAX);
               cells    = $urandom_range(0, MV_MAX);
               empty_mv = $urandom_range(0, MV_MAX);
               full_mv  = $urandom_range(0, MV_MAX);
            end
            default: begin
               // plausible pack: place empty..full around the cluster center
               gain     = $urandom_range(1, 16);
               cells    = $urandom_range(1, 8);
               cell_mv  = center_mv * gain / cells;
               span_mv  = $urandom_range(1, 2000);
               empty_mv = (cell_mv > span_mv) ? cell_mv - span_mv : 0;
               full_mv  = empty_mv + 2 * span_mv;
               if (full_mv > MV_MAX) full_mv = MV_MAX;
            end
         endcase
         write_all_csrs(gain, cells, empty_mv, full_mv);

         // some phases run back to back with no sender idling
         steady = ($urandom_range(0, 3) == 0);
         for (n = 0; n < PHASE_SAMPLES; n++) begin
            send_sample(pick_sample(center_mv), steady ? 0 : pick_gap());
         end
         finish_phase();
      end

      $display("%0d samples over %0d register settings, %0d register writes",
               samples_sent, settings_run, csr_writes);
      $display("%0d levels compared: %0d clamped empty, %0d clamped full, %0d in between",
               levels_checked, empty_levels, full_levels,
               levels_checked - empty_levels - full_levels);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d failures", fail_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== battery_level_averager.f =====
rtl/bla_pkg.sv
rtl/bla_cell.sv
rtl/bla_div.sv
rtl/battery_level_averager.sv
rtl/bla_checker.sv
sim/battery_level_averager_checker.sv
sim/battery_level_averager_tb.sv
